@@ sv/ipsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipsc_pkg
// Shared constants, codes and helper functions for the IPv4 packet
// statistics counter.
// ----------------------------------------------------------------------------
package ipsc_pkg;

    // Default number of destination table slots
    localparam int TABLE_ENTRIES_DEF = 256;

    // Counter limits
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    // Command codes
    localparam logic CMD_ACCOUNT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Protocol class codes
    localparam int          NUM_CLASSES = 5;
    localparam logic [2:0] CLASS_ICMP  = 3'd0;
    localparam logic [2:0] CLASS_IGMP  = 3'd1;
    localparam logic [2:0] CLASS_TCP   = 3'd2;
    localparam logic [2:0] CLASS_UDP   = 3'd3;
    localparam logic [2:0] CLASS_OTHER = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_READ
    } ipsc_state_t;

    // Map a protocol number to its class
    function automatic logic [2:0] class_of(input logic [7:0] proto);
        logic [2:0] c;
        case (proto)
            PROTO_ICMP: c = CLASS_ICMP;
            PROTO_IGMP: c = CLASS_IGMP;
            PROTO_TCP:  c = CLASS_TCP;
            PROTO_UDP:  c = CLASS_UDP;
            default:    c = CLASS_OTHER;
        endcase
        return c;
    endfunction

    // Saturating 32-bit increment
    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        logic [31:0] r;
        r = (v == MAX32) ? v : v + 32'd1;
        return r;
    endfunction

    // Saturating 48-bit accumulate of a 16-bit length
    function automatic logic [47:0] sat_add48(input logic [47:0] s, input logic [15:0] a);
        logic [48:0] r;
        r = {1'b0, s} + {33'd0, a};
        return r[48] ? MAX48 : r[47:0];
    endfunction

endpackage

@@ sv/ipv4_packet_statistics_counter.sv @@
// ----------------------------------------------------------------------------
// ipv4_packet_statistics_counter
// Per-packet IPv4 statistics: totals, protocol classes, a per-destination
// count table with sequential lookup, and the most frequent destination.
// ----------------------------------------------------------------------------
//  Channel   Prefix  Direction  Carries
//  input     s_      in         command, frame/IP lengths, dest, protocol, index
//  result    m_      out        entry data, flags, top talker, totals, class
//
//  A read command reads the slot from the table RAMs in the accept cycle; the
//  result is registered in ST_READ once the result register is free.
//  An account command scans the address RAM one slot per cycle over the used
//  slots until a hit (ST_SCAN), then writes back and updates in ST_UPDATE once
//  the result register is free.
//  Reset clears the running counters and the fill count at once; RAMs are not cleared.
//  A stalled result holds the next item in its final cycle until taken.
// ----------------------------------------------------------------------------
module ipv4_packet_statistics_counter
    import ipsc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_frame_length,
    input  logic [15:0] s_ip_total_length,
    input  logic [31:0] s_dest_addr,
    input  logic [7:0]  s_protocol_number,
    input  logic [7:0]  s_entry_index,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_dest_count,
    output logic [31:0] m_entry_addr,
    output logic        m_entry_valid,
    output logic        m_table_full,
    output logic [31:0] m_top_addr,
    output logic [31:0] m_top_count,
    output logic [31:0] m_packets_total,
    output logic [47:0] m_frame_bytes_total,
    output logic [47:0] m_ip_bytes_total,
    output logic [2:0]  m_protocol_class,
    output logic [31:0] m_protocol_count
);

    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    // Controller state
    ipsc_state_t state_reg, state_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] scan_ptr_reg, scan_ptr_next;
    logic [IW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          pend_reg, pend_next;

    // Latched word fields and lookup outcome
    logic [15:0] flen_reg, flen_next;
    logic [15:0] iplen_reg, iplen_next;
    logic [31:0] dest_reg, dest_next;
    logic [7:0]  proto_reg, proto_next;
    logic        rd_ok_reg, rd_ok_next;
    logic        counted_reg, counted_next;
    logic        alloc_reg, alloc_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0] cnt_reg, cnt_next;

    // Running totals
    logic [31:0] best_addr_reg, best_addr_next;
    logic [31:0] best_count_reg, best_count_next;
    logic [31:0] packets_reg, packets_next;
    logic [47:0] fbytes_reg, fbytes_next;
    logic [47:0] ipbytes_reg, ipbytes_next;
    logic [31:0] class_cnt_reg [0:NUM_CLASSES-1];
    logic [31:0] class_cnt_next [0:NUM_CLASSES-1];

    // Result register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] dcount_reg, dcount_next;
    logic [31:0] eaddr_reg, eaddr_next;
    logic        evalid_reg, evalid_next;
    logic        full_reg, full_next;
    logic [31:0] top_addr_reg, top_addr_next;
    logic [31:0] top_count_reg, top_count_next;
    logic [31:0] pkt_out_reg, pkt_out_next;
    logic [47:0] fb_out_reg, fb_out_next;
    logic [47:0] ipb_out_reg, ipb_out_next;
    logic [2:0]  pclass_reg, pclass_next;
    logic [31:0] pcount_reg, pcount_next;

    // Table RAM ports
    logic [IW-1:0] raddr;
    logic [31:0]   addr_rdata;
    logic [31:0]   count_rdata;
    logic          addr_we;
    logic          count_we;
    logic [31:0]   cnt_new;
    logic [2:0]    pclass;
    logic [31:0]   pcount_new;
    logic [CMPW-1:0] idx_ext;
    logic          out_free;

    ipsc_table_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (32)
    ) u_addr_ram (
        .aclk  (aclk),
        .we    (addr_we),
        .waddr (hit_idx_reg),
        .wdata (dest_reg),
        .raddr (raddr),
        .rdata (addr_rdata)
    );

    ipsc_table_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (32)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (count_we),
        .waddr (hit_idx_reg),
        .wdata (cnt_new),
        .raddr (raddr),
        .rdata (count_rdata)
    );

    assign idx_ext    = CMPW'(s_entry_index);
    assign out_free   = !m_valid_reg || m_ready;
    assign cnt_new    = sat_inc32(cnt_reg);
    assign pclass     = class_of(proto_reg);
    assign pcount_new = sat_inc32(class_cnt_reg[pclass]);
    assign s_ready    = (state_reg == ST_IDLE);

    // Next state, table access and result assembly
    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        scan_ptr_next   = scan_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_next       = pend_reg;
        flen_next       = flen_reg;
        iplen_next      = iplen_reg;
        dest_next       = dest_reg;
        proto_next      = proto_reg;
        rd_ok_next      = rd_ok_reg;
        counted_next    = counted_reg;
        alloc_next      = alloc_reg;
        hit_idx_next    = hit_idx_reg;
        cnt_next        = cnt_reg;
        best_addr_next  = best_addr_reg;
        best_count_next = best_count_reg;
        packets_next    = packets_reg;
        fbytes_next     = fbytes_reg;
        ipbytes_next    = ipbytes_reg;
        class_cnt_next  = class_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        dcount_next     = dcount_reg;
        eaddr_next      = eaddr_reg;
        evalid_next     = evalid_reg;
        full_next       = full_reg;
        top_addr_next   = top_addr_reg;
        top_count_next  = top_count_reg;
        pkt_out_next    = pkt_out_reg;
        fb_out_next     = fb_out_reg;
        ipb_out_next    = ipb_out_reg;
        pclass_next     = pclass_reg;
        pcount_next     = pcount_reg;
        raddr           = scan_ptr_reg[IW-1:0];
        addr_we         = 1'b0;
        count_we        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                // Start the table read with the word itself
                raddr = (s_command == CMD_READ) ? idx_ext[IW-1:0] : '0;
                if (s_valid) begin
                    flen_next   = s_frame_length;
                    iplen_next  = s_ip_total_length;
                    dest_next   = s_dest_addr;
                    proto_next  = s_protocol_number;
                    rd_ptr_next = raddr;
                    rd_ok_next  = idx_ext < CMPW'(used_reg);
                    if (s_command == CMD_READ) begin
                        state_next = ST_READ;
                    end else begin
                        scan_ptr_next = CW'(1);
                        pend_next     = (used_reg != '0);
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Compare the slot read last cycle, issue the next slot
                if (pend_reg && (addr_rdata == dest_reg)) begin
                    counted_next = 1'b1;
                    alloc_next   = 1'b0;
                    hit_idx_next = rd_ptr_reg;
                    cnt_next     = count_rdata;
                    state_next   = ST_UPDATE;
                end else if (scan_ptr_reg >= used_reg) begin
                    counted_next = (used_reg < CW'(TABLE_ENTRIES));
                    alloc_next   = 1'b1;
                    hit_idx_next = used_reg[IW-1:0];
                    cnt_next     = '0;
                    state_next   = ST_UPDATE;
                end else begin
                    pend_next     = 1'b1;
                    rd_ptr_next   = raddr;
                    scan_ptr_next = scan_ptr_reg + CW'(1);
                end
            end

            ST_UPDATE: begin
                // Write back the slot, advance totals and present the result
                if (out_free) begin
                    packets_next          = sat_inc32(packets_reg);
                    fbytes_next           = sat_add48(fbytes_reg, flen_reg);
                    ipbytes_next          = sat_add48(ipbytes_reg, iplen_reg);
                    class_cnt_next[pclass] = pcount_new;
                    top_addr_next         = best_addr_reg;
                    top_count_next        = best_count_reg;
                    if (counted_reg) begin
                        count_we = 1'b1;
                        addr_we  = alloc_reg;
                        if (alloc_reg) begin
                            used_next = used_reg + CW'(1);
                        end
                        if (cnt_new > best_count_reg) begin
                            best_addr_next  = dest_reg;
                            best_count_next = cnt_new;
                            top_addr_next   = dest_reg;
                            top_count_next  = cnt_new;
                        end
                    end
                    m_valid_next = 1'b1;
                    dcount_next  = counted_reg ? cnt_new : '0;
                    eaddr_next   = counted_reg ? dest_reg : '0;
                    evalid_next  = counted_reg;
                    full_next    = !counted_reg;
                    pkt_out_next = sat_inc32(packets_reg);
                    fb_out_next  = sat_add48(fbytes_reg, flen_reg);
                    ipb_out_next = sat_add48(ipbytes_reg, iplen_reg);
                    pclass_next  = pclass;
                    pcount_next  = pcount_new;
                    state_next   = ST_IDLE;
                end
            end

            ST_READ: begin
                // Hold the slot address so a stalled result keeps its data
                raddr = rd_ptr_reg;
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    dcount_next    = rd_ok_reg ? count_rdata : '0;
                    eaddr_next     = rd_ok_reg ? addr_rdata : '0;
                    evalid_next    = rd_ok_reg;
                    full_next      = 1'b0;
                    top_addr_next  = best_addr_reg;
                    top_count_next = best_count_reg;
                    pkt_out_next   = packets_reg;
                    fb_out_next    = fbytes_reg;
                    ipb_out_next   = ipbytes_reg;
                    pclass_next    = CLASS_ICMP;
                    pcount_next    = '0;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            pend_reg       <= 1'b0;
            best_addr_reg  <= '0;
            best_count_reg <= '0;
            packets_reg    <= '0;
            fbytes_reg     <= '0;
            ipbytes_reg    <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                class_cnt_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_reg       <= pend_next;
            best_addr_reg  <= best_addr_next;
            best_count_reg <= best_count_next;
            packets_reg    <= packets_next;
            fbytes_reg     <= fbytes_next;
            ipbytes_reg    <= ipbytes_next;
            m_valid_reg    <= m_valid_next;
            class_cnt_reg  <= class_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_ptr_reg  <= scan_ptr_next;
        rd_ptr_reg    <= rd_ptr_next;
        flen_reg      <= flen_next;
        iplen_reg     <= iplen_next;
        dest_reg      <= dest_next;
        proto_reg     <= proto_next;
        rd_ok_reg     <= rd_ok_next;
        counted_reg   <= counted_next;
        alloc_reg     <= alloc_next;
        hit_idx_reg   <= hit_idx_next;
        cnt_reg       <= cnt_next;
        dcount_reg    <= dcount_next;
        eaddr_reg     <= eaddr_next;
        evalid_reg    <= evalid_next;
        full_reg      <= full_next;
        top_addr_reg  <= top_addr_next;
        top_count_reg <= top_count_next;
        pkt_out_reg   <= pkt_out_next;
        fb_out_reg    <= fb_out_next;
        ipb_out_reg   <= ipb_out_next;
        pclass_reg    <= pclass_next;
        pcount_reg    <= pcount_next;
    end

    // Drive the result word
    assign m_valid             = m_valid_reg;
    assign m_dest_count        = dcount_reg;
    assign m_entry_addr        = eaddr_reg;
    assign m_entry_valid       = evalid_reg;
    assign m_table_full        = full_reg;
    assign m_top_addr          = top_addr_reg;
    assign m_top_count         = top_count_reg;
    assign m_packets_total     = pkt_out_reg;
    assign m_frame_bytes_total = fb_out_reg;
    assign m_ip_bytes_total    = ipb_out_reg;
    assign m_protocol_class    = pclass_reg;
    assign m_protocol_count    = pcount_reg;

endmodule

@@ sv/ipsc_table_ram.sv @@
// ----------------------------------------------------------------------------
// ipsc_table_ram
// Simple dual-port table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ipsc_table_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
